### rtl/sul_pkg.sv
// Package for the sorted unique list store.
// Holds sizes, request codes, word structs and the cell control struct.
// No dependencies.
`default_nettype none

package sul_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int ITEM_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int RSP_COUNT_WIDTH = 5;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_INSERT = 3'd1,
      OP_POP    = 3'd2,
      OP_REMOVE = 3'd3,
      OP_LOOKUP = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]            req_type;
      logic [ITEM_WIDTH-1:0] item_value;
   } req_word_type;

   typedef struct packed {
      logic                       success;
      logic [ITEM_WIDTH-1:0]      popped_value;
      logic                       found;
      logic [RSP_COUNT_WIDTH-1:0] entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic                   open_en;
      logic                   close_en;
      logic                   mark_all;
      logic                   mark_less;
      logic                   mark_equal;
      logic [VALUE_WIDTH-1:0] key;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### rtl/sul_cell.sv
// One cell of the list row: holds one entry and its valid bit.
// Shifts from its left or right neighbor on open or close. Uses sul_pkg.
`default_nettype none

module sul_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sul_pkg::cell_ctrl_type          ctrl,
   input  wire logic                            hit_in,
   input  wire logic [sul_pkg::VALUE_WIDTH-1:0] left_value,
   input  wire logic                            left_valid,
   input  wire logic [sul_pkg::VALUE_WIDTH-1:0] right_value,
   input  wire logic                            right_valid,
   output logic                                 hit_out,
   output logic                                 match,
   output logic [sul_pkg::VALUE_WIDTH-1:0]      value,
   output logic                                 valid
);
   import sul_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   valid_ff, valid_in;
   logic                   mark;
   logic                   here;

   assign match   = valid_ff && (value_ff == ctrl.key);
   assign mark    = ctrl.mark_all
                  | (ctrl.mark_less & !(valid_ff && (value_ff < ctrl.key)))
                  | (ctrl.mark_equal & match);
   assign hit_out = hit_in | mark;
   assign here    = mark & !hit_in;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.open_en) begin
         if (here) begin
            value_in = ctrl.key;
            valid_in = 1'b1;
         end else if (hit_in) begin
            value_in = left_value;
            valid_in = left_valid;
         end
      end else if (ctrl.close_en) begin
         if (here || hit_in) begin
            value_in = right_value;
            valid_in = right_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

### rtl/sorted_unique_list_store.sv
// Top level of the sorted unique list store: request decode, cell row, result register.
// Uses sul_pkg and sul_cell.
//
// Usage:
//   A request word (req_type, item_value) is taken on a clock edge with start high
//   and busy low. busy stays low: a new word may be given every cycle.
//   Every request gives one result word on rsp_word, marked by rsp_strobe for
//   exactly one cycle, in the cycle after the request is taken (throughput
//   one word per cycle). The receiver cannot stall; results are
//   issued in request order.
//   The entries sit in a row of CAPACITY cells. All cells compare against the
//   key in parallel; a prefix chain through the row marks the insert or delete
//   position, and each cell then loads the key, its left neighbor or its right
//   neighbor in the same cycle, so the rate is set by one compare plus the
//   prefix chain across the row.
//   Reset (synchronous) clears all valid bits and the count: the store is empty
//   and no result is pending. Entry values need no clearing.
`default_nettype none

module sorted_unique_list_store (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire sul_pkg::req_word_type req_word,
   output logic                       rsp_strobe,
   output sul_pkg::rsp_word_type      rsp_word
);
   import sul_pkg::*;

   cell_ctrl_type          ctrl;
   logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic                   cell_valid [CAPACITY];
   logic [CAPACITY:0]      hit_chain;
   logic [CAPACITY-1:0]    match_vec;

   logic                   accept;
   logic                   found;
   logic                   full;
   logic                   empty;
   logic                   ok;
   logic [ITEM_WIDTH-1:0]  popped;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_strobe_ff;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign found  = |match_vec;
   assign full   = (count_ff == COUNT_WIDTH'(CAPACITY));
   assign empty  = (count_ff == '0);

   always_comb begin
      ctrl       = '0;
      ctrl.key   = req_word.item_value[VALUE_WIDTH-1:0];
      ok         = 1'b0;
      popped     = '0;
      case (req_word.req_type)
         OP_PUSH: begin
            ok            = !full && !found;
            ctrl.open_en  = accept && ok;
            ctrl.mark_all = 1'b1;
         end
         OP_INSERT: begin
            ok             = !full && !found;
            ctrl.open_en   = accept && ok;
            ctrl.mark_less = 1'b1;
         end
         OP_POP: begin
            ok            = !empty;
            ctrl.close_en = accept && ok;
            ctrl.mark_all = 1'b1;
            if (ok) begin
               popped = ITEM_WIDTH'(cell_value[0]);
            end
         end
         OP_REMOVE: begin
            ok              = found;
            ctrl.close_en   = accept && ok;
            ctrl.mark_equal = 1'b1;
         end
         OP_LOOKUP: begin
            ok = found;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_value, right_value;
      logic                   left_valid, right_valid;

      if (i == 0) begin : g_head
         assign left_value = '0;
         assign left_valid = 1'b0;
      end else begin : g_mid_left
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid_right
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      sul_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .hit_in      (hit_chain[i]),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (right_value),
         .right_valid (right_valid),
         .hit_out     (hit_chain[i+1]),
         .match       (match_vec[i]),
         .value       (cell_value[i]),
         .valid       (cell_valid[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.open_en) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (ctrl.close_en) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
      rsp_word_in.success      = ok;
      rsp_word_in.popped_value = popped;
      rsp_word_in.found        = found;
      rsp_word_in.entry_count  = RSP_COUNT_WIDTH'(count_in);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

`default_nettype wire

### bench/sorted_unique_list_store_test.sv
// Self-checking bench for sorted_unique_list_store: a directed table, then random
// push/insert/pop/remove/lookup and spare-code traffic with bursty start, checked
// against a local model. Depends on sul_pkg and the sorted_unique_list_store RTL.
`default_nettype none

module sorted_unique_list_store_test;

   import sul_pkg::*;

   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int WORD_TARGET = 1950;

   typedef struct {
      logic [2:0]   op;
      logic [31:0]  val;
      bit           typed;
      rsp_word_type rsp;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   req_word_type req_word = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   logic [31:0]  held_values [CAPACITY];
   int           held_count = 0;
   logic [31:0]  value_pool [24];
   rsp_word_type pending_outcomes [$];
   rsp_word_type due_rsp;
   int           error_count = 0;
   int           words_sent = 0;
   int           burst_left = 1;

   // typed rows: {success, popped_value, found, entry_count}
   directed_row_type plan [24] = '{
      '{OP_LOOKUP,  32'h0,        1'b1, {1'b0, 32'h0,   1'b0, 5'd0}},
      '{OP_POP,     32'hFFFFFFFF, 1'b1, {1'b0, 32'h0,   1'b0, 5'd0}},
      '{OP_REMOVE,  32'h0,        1'b1, {1'b0, 32'h0,   1'b0, 5'd0}},
      '{OP_PUSH,    32'h0,        1'b1, {1'b1, 32'h0,   1'b0, 5'd1}},
      '{OP_PUSH,    32'hFFFFFFFF, 1'b1, {1'b1, 32'h0,   1'b0, 5'd2}},
      '{OP_PUSH,    32'h0,        1'b1, {1'b0, 32'h0,   1'b1, 5'd2}},
      '{OP_INSERT,  32'hFFFFFFFF, 1'b1, {1'b0, 32'h0,   1'b1, 5'd2}},
      '{OP_INSERT,  32'd100,      1'b0, '0},
      '{OP_INSERT,  32'h7FFFFFFF, 1'b0, '0},
      '{OP_LOOKUP,  32'd100,      1'b1, {1'b1, 32'h0,   1'b1, 5'd4}},
      '{OP_SPARE_5, 32'd100,      1'b1, {1'b0, 32'h0,   1'b1, 5'd4}},
      '{OP_SPARE_6, 32'd7,        1'b1, {1'b0, 32'h0,   1'b0, 5'd4}},
      '{OP_SPARE_7, 32'hFFFFFFFF, 1'b1, {1'b0, 32'h0,   1'b1, 5'd4}},
      '{OP_POP,     32'h0,        1'b1, {1'b1, 32'd100, 1'b1, 5'd3}},
      '{OP_POP,     32'd5,        1'b0, '0},
      '{OP_REMOVE,  32'd12345,    1'b1, {1'b0, 32'h0,   1'b0, 5'd2}},
      '{OP_REMOVE,  32'hFFFFFFFF, 1'b1, {1'b1, 32'h0,   1'b1, 5'd1}},
      '{OP_INSERT,  32'hAAAAAAAA, 1'b0, '0},
      '{OP_INSERT,  32'h55555555, 1'b0, '0},
      '{OP_LOOKUP,  32'h55555555, 1'b0, '0},
      '{OP_REMOVE,  32'h0,        1'b0, '0},
      '{OP_POP,     32'h0,        1'b0, '0},
      '{OP_POP,     32'h0,        1'b0, '0},
      '{OP_POP,     32'h0,        1'b1, {1'b0, 32'h0,   1'b0, 5'd0}}
   };

   sorted_unique_list_store DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the local copy of the store and returns its outcome.
   function automatic rsp_word_type store_outcome(input logic [2:0] op,
                                                  input logic [31:0] val);
      rsp_word_type r;
      logic         hit;
      logic         drop;
      int           where;
      int           pos;
      r = '0;
      hit = 1'b0;
      drop = 1'b0;
      where = 0;
      pos = 0;
      for (int i = 0; i < held_count; i++) begin
         if (!hit && held_values[i] == val) begin
            hit = 1'b1;
            where = i;
         end
      end
      case (op)
         OP_PUSH, OP_INSERT: begin
            if (held_count < CAPACITY && !hit) begin
               if (op == OP_INSERT) begin
                  while (pos < held_count && held_values[pos] < val) pos++;
               end
               for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
               held_values[pos] = val;
               held_count++;
               r.success = 1'b1;
            end
         end
         OP_POP: begin
            if (held_count > 0) begin
               r.popped_value = held_values[0];
               where = 0;
               drop = 1'b1;
            end
         end
         OP_REMOVE: drop = hit;
         OP_LOOKUP: r.success = hit;
         default: ;
      endcase
      if (drop) begin
         for (int i = where; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
         held_count--;
         r.success = 1'b1;
      end
      r.found = hit;
      r.entry_count = RSP_COUNT_WIDTH'(held_count);
      return r;
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'h0;
         1: v = 32'hFFFFFFFF;
         2, 3: v = $urandom;
         4, 5, 6: v = value_pool[$urandom_range(0, 23)];
         default: v = (held_count > 0) ? held_values[$urandom_range(0, held_count - 1)]
                                       : $urandom;
      endcase
      return v;
   endfunction

   // Drives one word, waits for it to be taken, then may drop start for a gap.
   task automatic send_word(input logic [2:0] op, input logic [31:0] val,
                            input bit typed, input rsp_word_type typed_rsp);
      rsp_word_type predicted;
      start <= 1'b1;
      req_word <= {op, val};
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = store_outcome(op, val);
      pending_outcomes.push_back(typed ? typed_rsp : predicted);
      if (op <= OP_LOOKUP) words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         req_word <= {3'($urandom_range(0, 7)), 32'($urandom)};
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 3))
            @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result word: %h", rsp_word);
            error_count++;
         end else begin
            due_rsp = pending_outcomes.pop_front();
            if (rsp_word.success !== due_rsp.success) begin
               $error("success: expected %0d, got %0d", due_rsp.success, rsp_word.success);
               error_count++;
            end
            if (rsp_word.popped_value !== due_rsp.popped_value) begin
               $error("popped_value: expected %h, got %h",
                      due_rsp.popped_value, rsp_word.popped_value);
               error_count++;
            end
            if (rsp_word.found !== due_rsp.found) begin
               $error("found: expected %0d, got %0d", due_rsp.found, rsp_word.found);
               error_count++;
            end
            if (rsp_word.entry_count !== due_rsp.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      due_rsp.entry_count, rsp_word.entry_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("sorted_unique_list_store_test: done, errors");
      $finish;
   end

   initial begin
      logic [2:0] op;
      for (int i = 0; i < 24; i++)
         value_pool[i] = (i < 10) ? 32'($urandom_range(0, 40)) : 32'($urandom);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) send_word(plan[i].op, plan[i].val, plan[i].typed, plan[i].rsp);

      while (words_sent < WORD_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // fill to capacity, bump against full, then drain to empty and hit empty once more
               while (held_count < CAPACITY) begin
                  op = ($urandom_range(0, 2) == 0) ? OP_PUSH : OP_INSERT;
                  send_word(op, pick_value(), 1'b0, '0);
               end
               repeat ($urandom_range(1, 4)) begin
                  op = $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
                  send_word(op, pick_value(), 1'b0, '0);
               end
               repeat ($urandom_range(0, 4)) send_word(OP_LOOKUP, pick_value(), 1'b0, '0);
               while (held_count > 0) begin
                  op = $urandom_range(0, 1) ? OP_POP : OP_REMOVE;
                  send_word(op, pick_value(), 1'b0, '0);
               end
               send_word($urandom_range(0, 1) ? OP_POP : OP_REMOVE, pick_value(), 1'b0, '0);
            end
            4, 5, 6, 7, 8: begin
               repeat ($urandom_range(10, 40)) begin
                  op = 3'($urandom_range(OP_PUSH, OP_LOOKUP));
                  send_word(op, pick_value(), 1'b0, '0);
               end
            end
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
                  send_word(op, $urandom_range(0, 1) ? pick_value() : 32'($urandom),
                            1'b0, '0);
               end
            end
         endcase
      end

      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("sorted_unique_list_store_test: done, clean");
      else
         $display("sorted_unique_list_store_test: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
